>>> rtl/core/alu8f_pkg.sv
// shared types and constants of the eight-operation alu
`timescale 1ns / 1ps

package alu8f_pkg;

  // default operand width
  localparam int DATA_WIDTH_DEF = 16;

  // width of the command field
  localparam int CMD_W = 3;

  // operation codes
  typedef enum logic [CMD_W-1:0] {
    CMD_AND  = 3'd0,
    CMD_OR   = 3'd1,
    CMD_XOR  = 3'd2,
    CMD_ROTR = 3'd3,
    CMD_ROTL = 3'd4,
    CMD_ADD  = 3'd5,
    CMD_MUL  = 3'd6,
    CMD_DIV  = 3'd7
  } cmd_e;

  // status flags of one result
  typedef struct packed {
    logic zero;
    logic carry;
    logic negative;
    logic overflow;
    logic underflow;
  } flags_t;

endpackage

>>> rtl/core/alu8f_in_if.sv
// operation channel: two operands and a command with valid/ready handshake
`timescale 1ns / 1ps

interface alu8f_in_if #(
  parameter int DATA_WIDTH = alu8f_pkg::DATA_WIDTH_DEF
);
  import alu8f_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] operand_a;
  logic signed [DATA_WIDTH-1:0] operand_b;
  logic        [CMD_W-1:0]      command;

  modport source (output valid, output operand_a, output operand_b, output command,
                  input ready);
  modport sink (input valid, input operand_a, input operand_b, input command,
                output ready);
endinterface

>>> rtl/core/alu8f_out_if.sv
// result channel: wrapped result and five flags with valid/ready handshake
`timescale 1ns / 1ps

interface alu8f_out_if #(
  parameter int DATA_WIDTH = alu8f_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] result;
  logic                         zero_flag;
  logic                         carry_flag;
  logic                         negative_flag;
  logic                         overflow_flag;
  logic                         underflow_flag;

  modport source (output valid, output result, output zero_flag, output carry_flag,
                  output negative_flag, output overflow_flag, output underflow_flag,
                  input ready);
  modport sink (input valid, input result, input zero_flag, input carry_flag,
                input negative_flag, input overflow_flag, input underflow_flag,
                output ready);
endinterface

>>> rtl/core/alu8f_front.sv
// operand setup ahead of the cell chain: logic ops, rotates, add, mul/div seeds
`timescale 1ns / 1ps

module alu8f_front #(
  parameter int DATA_WIDTH = alu8f_pkg::DATA_WIDTH_DEF
) (
  input  logic signed [DATA_WIDTH-1:0]                      operand_a_i,
  input  logic signed [DATA_WIDTH-1:0]                      operand_b_i,
  input  logic        [alu8f_pkg::CMD_W-1:0]                command_i,
  output logic        [5*DATA_WIDTH+alu8f_pkg::CMD_W-1:0]   work_o
);
  import alu8f_pkg::*;

  typedef struct packed {
    cmd_e                  cmd;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0] acc;
    logic [DATA_WIDTH-1:0] q;
    logic [DATA_WIDTH-1:0] d;
  } work_t;

  work_t                 work;
  logic [DATA_WIDTH-1:0] a_u;
  logic [DATA_WIDTH-1:0] b_u;
  logic [DATA_WIDTH-1:0] a_mag;
  logic [DATA_WIDTH-1:0] b_mag;

  assign a_u   = operand_a_i;
  assign b_u   = operand_b_i;
  // magnitudes for the divider, most negative value maps to itself unsigned
  assign a_mag = a_u[DATA_WIDTH-1] ? (~a_u + 1'b1) : a_u;
  assign b_mag = b_u[DATA_WIDTH-1] ? (~b_u + 1'b1) : b_u;

  // logic, rotate and add results finish here, mul and div get their seeds
  always_comb begin
    work     = '0;
    work.cmd = cmd_e'(command_i);
    work.a   = a_u;
    work.b   = b_u;
    unique case (work.cmd)
      CMD_AND:  work.acc = a_u & b_u;
      CMD_OR:   work.acc = a_u | b_u;
      CMD_XOR:  work.acc = a_u ^ b_u;
      CMD_ROTR: work.acc = {a_u[0], a_u[DATA_WIDTH-1:1]};
      CMD_ROTL: work.acc = {a_u[DATA_WIDTH-2:0], a_u[DATA_WIDTH-1]};
      CMD_ADD:  work.acc = a_u + b_u;
      CMD_MUL: begin
        work.q = b_u;
        work.d = a_u;
      end
      CMD_DIV: begin
        work.q = a_mag;
        work.d = b_mag;
      end
      default: work.acc = '0;
    endcase
  end

  assign work_o = work;

endmodule

>>> rtl/core/alu8f_cell.sv
// one pipeline cell: a shift-add multiply bit or a restoring divide bit
`timescale 1ns / 1ps

module alu8f_cell #(
  parameter int DATA_WIDTH = alu8f_pkg::DATA_WIDTH_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            valid_i,
  input  logic [5*DATA_WIDTH+alu8f_pkg::CMD_W-1:0]        work_i,
  input  logic                                            ready_i,
  output logic                                            valid_o,
  output logic [5*DATA_WIDTH+alu8f_pkg::CMD_W-1:0]        work_o,
  output logic                                            ready_o
);
  import alu8f_pkg::*;

  typedef struct packed {
    cmd_e                  cmd;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0] acc;
    logic [DATA_WIDTH-1:0] q;
    logic [DATA_WIDTH-1:0] d;
  } work_t;

  work_t                 work_in;
  work_t                 work_d;
  work_t                 work_q;
  logic                  valid_q;
  logic [DATA_WIDTH-1:0] rem;

  assign work_in = work_i;

  // stage can load when empty or when its content moves on
  assign ready_o = !valid_q || ready_i;

  // partial remainder with the next dividend bit shifted in
  assign rem = {work_in.acc[DATA_WIDTH-2:0], work_in.q[DATA_WIDTH-1]};

  // one step of the iterative units, other ops pass through
  always_comb begin
    work_d = work_in;
    case (work_in.cmd)
      CMD_MUL: begin
        work_d.acc = work_in.acc + (work_in.q[0] ? work_in.d : '0);
        work_d.q   = work_in.q >> 1;
        work_d.d   = work_in.d << 1;
      end
      CMD_DIV: begin
        if (rem >= work_in.d) begin
          work_d.acc = rem - work_in.d;
          work_d.q   = {work_in.q[DATA_WIDTH-2:0], 1'b1};
        end else begin
          work_d.acc = rem;
          work_d.q   = {work_in.q[DATA_WIDTH-2:0], 1'b0};
        end
      end
      default: work_d = work_in;
    endcase
  end

  // stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

>>> rtl/core/alu8f_flags.sv
// result select, quotient sign fix-up and flag rules behind the cell chain
`timescale 1ns / 1ps

module alu8f_flags #(
  parameter int DATA_WIDTH = alu8f_pkg::DATA_WIDTH_DEF
) (
  input  logic        [5*DATA_WIDTH+alu8f_pkg::CMD_W-1:0] work_i,
  output logic signed [DATA_WIDTH-1:0]                    result_o,
  output alu8f_pkg::flags_t                               flags_o
);
  import alu8f_pkg::*;

  typedef struct packed {
    cmd_e                  cmd;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0] acc;
    logic [DATA_WIDTH-1:0] q;
    logic [DATA_WIDTH-1:0] d;
  } work_t;

  work_t                 work;
  logic [DATA_WIDTH-1:0] res;
  logic                  div_zero;
  logic                  a_pos;
  logic                  a_neg;
  logic                  b_pos;
  logic                  b_neg;
  logic                  r_pos;
  logic                  r_neg;
  logic                  of;
  logic                  uf;

  assign work = work_i;

  // final result
  always_comb begin
    div_zero = 1'b0;
    res      = work.acc;
    if (work.cmd == CMD_DIV) begin
      div_zero = (work.b == '0);
      if (div_zero) begin
        res = '0;
      end else if (work.a[DATA_WIDTH-1] ^ work.b[DATA_WIDTH-1]) begin
        res = ~work.q + 1'b1;
      end else begin
        res = work.q;
      end
    end
  end

  // operand and result signs
  assign a_neg = work.a[DATA_WIDTH-1];
  assign b_neg = work.b[DATA_WIDTH-1];
  assign r_neg = res[DATA_WIDTH-1];
  assign a_pos = (work.a != '0) && !a_neg;
  assign b_pos = (work.b != '0) && !b_neg;
  assign r_pos = (res != '0) && !r_neg;

  // overflow and underflow by operation
  always_comb begin
    of = 1'b0;
    uf = 1'b0;
    case (work.cmd) inside
      CMD_AND, CMD_OR, CMD_XOR, CMD_ADD: begin
        of = a_pos && b_pos && r_neg;
        uf = a_neg && b_neg && r_pos;
      end
      CMD_ROTR, CMD_ROTL: begin
        of = a_pos && r_neg;
        uf = a_neg && r_pos;
      end
      CMD_MUL: begin
        if (a_pos && b_pos) begin
          of = ($signed(res) < $signed(work.a)) || ($signed(res) < $signed(work.b));
        end else if (a_pos && b_neg) begin
          uf = $signed(work.b) < $signed(res);
        end else if (a_neg && b_pos) begin
          uf = $signed(work.a) < $signed(res);
        end else if (a_neg && b_neg) begin
          uf = r_neg;
        end
      end
      CMD_DIV: begin
        of = div_zero;
        uf = div_zero;
      end
      default: begin
        of = 1'b0;
        uf = 1'b0;
      end
    endcase
  end

  assign flags_o.zero      = !div_zero && (res == '0);
  assign flags_o.negative  = !div_zero && r_neg;
  assign flags_o.carry     = (work.cmd == CMD_ADD) && ($signed(work.a) < $signed(res));
  assign flags_o.overflow  = of;
  assign flags_o.underflow = uf;
  assign result_o          = res;

endmodule

>>> rtl/core/alu_eight_op_with_flags.sv
// Signed eight-operation ALU with zero, carry, negative, overflow, underflow.
//
// in_if carries operand_a, operand_b and command (and, or, xor, rotate right,
// rotate left, add, multiply low half, signed divide toward zero); a transfer
// happens on a rising edge with valid and ready high. out_if returns one
// result with its five flags per operation, in order.
// Every operation runs through a chain of DATA_WIDTH cells; each cell does
// one shift-add multiply bit or one restoring divide bit and passes the rest
// along; out_if.valid rises once the operation has been registered in all
// DATA_WIDTH cells; one operation is taken per cycle while the chain is not
// stalled by the receiver.
// The last cell register is the output stage; result and flags are decoded
// from it. Each cell loads when it is empty or its content moves on, so a
// stalled receiver only holds back the cells behind a waiting result and
// in_if.ready stays high while any cell in the chain is free.
// Reset clears all cell valid bits asynchronously; no result is pending after.
// Divide by zero gives result 0 with overflow and underflow set.
`timescale 1ns / 1ps

module alu_eight_op_with_flags #(
  parameter int DATA_WIDTH = alu8f_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  alu8f_in_if.sink    in_if,
  alu8f_out_if.source out_if
);
  import alu8f_pkg::*;

  localparam int WORK_W = 5 * DATA_WIDTH + CMD_W;

  logic                         valid_c [DATA_WIDTH+1];
  logic                         rdy_c   [DATA_WIDTH+1];
  logic [WORK_W-1:0]            work_c  [DATA_WIDTH+1];
  logic signed [DATA_WIDTH-1:0] result;
  flags_t                       flags;

  // operand setup
  alu8f_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .operand_a_i(in_if.operand_a),
    .operand_b_i(in_if.operand_b),
    .command_i  (in_if.command),
    .work_o     (work_c[0])
  );

  assign valid_c[0]          = in_if.valid;
  assign in_if.ready         = rdy_c[0];
  assign rdy_c[DATA_WIDTH]   = out_if.ready;

  // chain of cells
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    alu8f_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_c[i]),
      .work_i (work_c[i]),
      .ready_i(rdy_c[i+1]),
      .valid_o(valid_c[i+1]),
      .work_o (work_c[i+1]),
      .ready_o(rdy_c[i])
    );
  end

  // result and flags from the last cell
  alu8f_flags #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_flags (
    .work_i  (work_c[DATA_WIDTH]),
    .result_o(result),
    .flags_o (flags)
  );

  assign out_if.valid          = valid_c[DATA_WIDTH];
  assign out_if.result         = result;
  assign out_if.zero_flag      = flags.zero;
  assign out_if.carry_flag     = flags.carry;
  assign out_if.negative_flag  = flags.negative;
  assign out_if.overflow_flag  = flags.overflow;
  assign out_if.underflow_flag = flags.underflow;

endmodule

>>> rtl/core/alu8f_checker.sv
// port-level assertions for the alu and the bind that attaches them
`timescale 1ns / 1ps

module alu8f_checker #(
  parameter int DATA_WIDTH = alu8f_pkg::DATA_WIDTH_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] result_i,
  input logic                  zero_i,
  input logic                  negative_i,
  input logic                  overflow_i,
  input logic                  underflow_i
);

  // no result is offered while reset is held
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // a waiting result stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before transfer");

  // both overflow flags only come from divide by zero
  a_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && overflow_i && underflow_i |->
      (result_i == '0) && !zero_i && !negative_i)
    else $error("divide by zero result or flags wrong");

  // zero and negative follow the result otherwise
  a_zero_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !(overflow_i && underflow_i) |->
      (zero_i == (result_i == '0)) && (negative_i == result_i[DATA_WIDTH-1]))
    else $error("zero or negative flag disagrees with result");

endmodule

bind alu_eight_op_with_flags alu8f_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_alu8f_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .result_i   (out_if.result),
  .zero_i     (out_if.zero_flag),
  .negative_i (out_if.negative_flag),
  .overflow_i (out_if.overflow_flag),
  .underflow_i(out_if.underflow_flag)
);
